@@ rtl/pli_pkg.sv @@
// ----------------------------------------------------------------------------
// pli_pkg - shared types and constants
// Request item layout, mode and state encodings, and Q16.16 limits used by
// the interpolator front end, back end and top level.
// ----------------------------------------------------------------------------
package pli_pkg;

   // request action codes
   localparam logic ACT_WRITE = 1'b0;
   localparam logic ACT_EVAL  = 1'b1;

   // configuration register indexes
   localparam logic [1:0] CSR_POINT_COUNT = 2'd0;
   localparam logic [1:0] CSR_BELOW_MODE  = 2'd1;
   localparam logic [1:0] CSR_FALLBACK    = 2'd2;

   // raw below-range mode codes as written over the CSR port
   localparam logic [1:0] MODE_CODE_ERROR    = 2'd0;
   localparam logic [1:0] MODE_CODE_EXTRAP   = 2'd1;
   localparam logic [1:0] MODE_CODE_FALLBACK = 2'd2;
   localparam logic [1:0] MODE_CODE_SPARE    = 2'd3;  // behaves as fallback

   // Q16.16 saturation limits
   localparam logic signed [31:0] Q_MAX = 32'sh7FFF_FFFF;
   localparam logic signed [31:0] Q_MIN = 32'sh8000_0000;

   // magnitude width of the exact differences, and quotient bits produced
   localparam int MAG_W     = 33;
   localparam int DIV_STEPS = 33;

   typedef enum logic [1:0] {
      MODE_ERROR,
      MODE_EXTRAP,
      MODE_FALLBACK
   } mode_type;

   typedef enum logic [3:0] {
      B_IDLE,
      B_CMP0,
      B_SEARCH,
      B_DIFF,
      B_MLO,
      B_MHI,
      B_MSUM,
      B_DIVI,
      B_DIV,
      B_FIN
   } back_state_type;

   // one classified request as it travels from front to back
   typedef struct packed {
      logic                is_eval;
      logic                write_ok;
      logic [3:0]          idx;
      logic signed [31:0]  x;
      logic signed [31:0]  y;
      logic signed [4:0]   hint;
      mode_type            mode;
   } item_type;

endpackage

@@ rtl/piecewise_linear_interpolator_core.sv @@
// ----------------------------------------------------------------------------
// piecewise_linear_interpolator_core - Q16.16 breakpoint table interpolator
// Writes breakpoints and evaluates queries by linear interpolation between
// neighboring points, with selectable below-range behavior.
// ----------------------------------------------------------------------------
//  channel | direction | handshake          | payload
//  req_    | in        | push / full        | action, entry_index, x, y, hint
//  rsp_    | out       | empty / pop        | y_result, segment_index, status
//  csr_    | in        | valid / ready      | index, wdata
//
//  An evaluate walks one segment per cycle (up to MAX_POINTS-1 segments) over
//  the table read port, then forms the differences and runs the two-part
//  multiply and the bit-per-cycle divider; a zero difference skips both, and
//  a saturating quotient skips the divider. Reset is synchronous; the table
//  holds no reset value. A two-entry request queue keeps accepting while the
//  engine or a waiting response stalls, until both of its entries are held.
// ----------------------------------------------------------------------------
module piecewise_linear_interpolator_core import pli_pkg::*; #(
   parameter int MAX_POINTS = 16
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_push,
   output logic               req_full,
   input  logic               req_action,
   input  logic [3:0]         req_entry_index,
   input  logic signed [31:0] req_x_value,
   input  logic signed [31:0] req_y_value,
   input  logic signed [4:0]  req_segment_hint,
   output logic               rsp_empty,
   input  logic               rsp_pop,
   output logic signed [31:0] rsp_y_result,
   output logic signed [4:0]  rsp_segment_index,
   output logic               rsp_status,
   input  logic               csr_valid,
   output logic               csr_ready,
   input  logic [1:0]         csr_index,
   input  logic [31:0]        csr_wdata
);

   logic [4:0]         point_count_ff;
   logic [1:0]         mode_ff;
   logic signed [31:0] fallback_ff;
   logic               q_valid, q_pop;
   item_type           q_item;

   // configuration registers
   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         point_count_ff <= 5'd2;
         mode_ff        <= MODE_CODE_ERROR;
         fallback_ff    <= '0;
      end else if (csr_valid && csr_ready) begin
         case (csr_index)
            CSR_POINT_COUNT: point_count_ff <= csr_wdata[4:0];
            CSR_BELOW_MODE:  mode_ff        <= csr_wdata[1:0];
            CSR_FALLBACK:    fallback_ff    <= csr_wdata;
            default: begin
            end
         endcase
      end
   end

   pli_front #(.MAX_POINTS(MAX_POINTS)) u_front (
      .clock            (clock),
      .reset            (reset),
      .req_push         (req_push),
      .req_full         (req_full),
      .req_action       (req_action),
      .req_entry_index  (req_entry_index),
      .req_x_value      (req_x_value),
      .req_y_value      (req_y_value),
      .req_segment_hint (req_segment_hint),
      .mode_code        (mode_ff),
      .q_valid          (q_valid),
      .q_item           (q_item),
      .q_pop            (q_pop)
   );

   pli_back #(.MAX_POINTS(MAX_POINTS)) u_back (
      .clock             (clock),
      .reset             (reset),
      .q_valid           (q_valid),
      .q_item            (q_item),
      .q_pop             (q_pop),
      .point_count       (point_count_ff),
      .fallback_value    (fallback_ff),
      .rsp_empty         (rsp_empty),
      .rsp_pop           (rsp_pop),
      .rsp_y_result      (rsp_y_result),
      .rsp_segment_index (rsp_segment_index),
      .rsp_status        (rsp_status)
   );

endmodule

@@ rtl/pli_front.sv @@
// ----------------------------------------------------------------------------
// pli_front - request intake and classification
// Accepts requests, decodes the action and below-range mode, checks the
// write index against the table depth and holds items in a two-entry queue.
// ----------------------------------------------------------------------------
module pli_front import pli_pkg::*; #(
   parameter int MAX_POINTS = 16
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_push,
   output logic               req_full,
   input  logic               req_action,
   input  logic [3:0]         req_entry_index,
   input  logic signed [31:0] req_x_value,
   input  logic signed [31:0] req_y_value,
   input  logic signed [4:0]  req_segment_hint,
   input  logic [1:0]         mode_code,
   output logic               q_valid,
   output item_type           q_item,
   input  logic               q_pop
);

   item_type   slot_ff [2];
   logic       wr_ptr_ff, wr_ptr_in;
   logic       rd_ptr_ff, rd_ptr_in;
   logic [1:0] count_ff, count_in;
   item_type   new_item;
   logic       push_ok;

   // classify the incoming request
   always_comb begin
      new_item.is_eval  = (req_action == ACT_EVAL);
      new_item.write_ok = (int'(req_entry_index) < MAX_POINTS);
      new_item.idx      = req_entry_index;
      new_item.x        = req_x_value;
      new_item.y        = req_y_value;
      new_item.hint     = req_segment_hint;
      case (mode_code)
         MODE_CODE_ERROR:  new_item.mode = MODE_ERROR;
         MODE_CODE_EXTRAP: new_item.mode = MODE_EXTRAP;
         default:          new_item.mode = MODE_FALLBACK;
      endcase
   end

   assign req_full = (count_ff == 2'd2);
   assign push_ok  = req_push && !req_full;
   assign q_valid  = (count_ff != 2'd0);
   assign q_item   = slot_ff[rd_ptr_ff];

   // queue pointers
   always_comb begin
      wr_ptr_in = push_ok ? !wr_ptr_ff : wr_ptr_ff;
      rd_ptr_in = q_pop ? !rd_ptr_ff : rd_ptr_ff;
      count_in  = count_ff + {1'b0, push_ok} - {1'b0, q_pop};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         count_ff  <= 2'd0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // queue storage
   always_ff @(posedge clock) begin
      if (push_ok) begin
         slot_ff[wr_ptr_ff] <= new_item;
      end
   end

endmodule

@@ rtl/pli_back.sv @@
// ----------------------------------------------------------------------------
// pli_back - breakpoint table, segment search and interpolation engine
// Holds the breakpoint memory, walks the segments one per cycle, then runs
// a split multiply and a restoring divide, and parks the response.
// ----------------------------------------------------------------------------
module pli_back import pli_pkg::*; #(
   parameter int MAX_POINTS = 16
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               q_valid,
   input  item_type           q_item,
   output logic               q_pop,
   input  logic [4:0]         point_count,
   input  logic signed [31:0] fallback_value,
   output logic               rsp_empty,
   input  logic               rsp_pop,
   output logic signed [31:0] rsp_y_result,
   output logic signed [4:0]  rsp_segment_index,
   output logic               rsp_status
);

   localparam int AW = (MAX_POINTS > 2) ? $clog2(MAX_POINTS) : 1;
   localparam int CW = (AW > 4) ? AW : 4;

   back_state_type state_ff, state_in;
   item_type       item_ff, item_in;
   logic [AW-1:0]  seg_ff, seg_in;
   logic           force_ff, force_in;
   logic signed [31:0] x0_ff, x0_in, y0_ff, y0_in, x1_ff, x1_in, y1_ff, y1_in;
   logic [MAG_W-1:0] ma_ff, ma_in, mb_ff, mb_in, mc_ff, mc_in;
   logic           neg_ff, neg_in, sat_ff, sat_in;
   logic [48:0]    plo_ff, plo_in;
   logic [49:0]    phi_ff, phi_in;
   logic [65:0]    prod_ff, prod_in;
   logic [MAG_W-1:0] rem_ff, rem_in, plow_ff, plow_in, quo_ff, quo_in;
   logic [5:0]     cnt_ff, cnt_in;

   logic               res_valid_ff, res_valid_in;
   logic signed [31:0] res_y_ff, res_y_in;
   logic signed [4:0]  res_seg_ff, res_seg_in;
   logic               res_status_ff, res_status_in;
   logic               res_load;

   // breakpoint memory
   logic signed [31:0] mem_x_ff [MAX_POINTS];
   logic signed [31:0] mem_y_ff [MAX_POINTS];
   logic signed [31:0] rd_x_ff, rd_y_ff;
   logic [AW-1:0]      rd_addr;
   logic               mem_we;

   // helpers
   logic [AW-1:0]      n_last;
   logic [AW:0]        seg_p1, seg_p2;
   logic               is_last, hint_hit, hit;
   logic signed [32:0] dx, dy, den;
   logic [MAG_W:0]     r2;
   logic               ge;
   logic signed [34:0] sum;

   // last valid point index, with the count clamped to the table
   always_comb begin
      if (point_count < 5'd2) begin
         n_last = AW'(1);
      end else if (int'(point_count) > MAX_POINTS) begin
         n_last = AW'(MAX_POINTS - 1);
      end else begin
         n_last = AW'(point_count - 5'd1);
      end
   end

   // search helpers
   always_comb begin
      seg_p1   = {1'b0, seg_ff} + (AW+1)'(1);
      seg_p2   = {1'b0, seg_ff} + (AW+1)'(2);
      is_last  = (seg_p1 == {1'b0, n_last});
      hint_hit = !item_ff.hint[4] && (CW'(item_ff.hint[3:0]) == CW'(seg_ff));
      hit      = force_ff || (hint_hit ? (item_ff.x <= rd_x_ff) : (item_ff.x < rd_x_ff));
      dx       = 33'(item_ff.x) - 33'(x0_ff);
      dy       = 33'(y1_ff) - 33'(y0_ff);
      den      = 33'(x1_ff) - 33'(x0_ff);
      r2       = {rem_ff, plow_ff[MAG_W-1]};
      ge       = (r2 >= {1'b0, mc_ff});
      sum      = neg_ff ? (35'(y0_ff) - 35'({2'b00, quo_ff}))
                        : (35'(y0_ff) + 35'({2'b00, quo_ff}));
   end

   // sequencer
   always_comb begin
      state_in      = state_ff;
      item_in       = item_ff;
      seg_in        = seg_ff;
      force_in      = force_ff;
      x0_in         = x0_ff;
      y0_in         = y0_ff;
      x1_in         = x1_ff;
      y1_in         = y1_ff;
      ma_in         = ma_ff;
      mb_in         = mb_ff;
      mc_in         = mc_ff;
      neg_in        = neg_ff;
      sat_in        = sat_ff;
      plo_in        = plo_ff;
      phi_in        = phi_ff;
      prod_in       = prod_ff;
      rem_in        = rem_ff;
      plow_in       = plow_ff;
      quo_in        = quo_ff;
      cnt_in        = cnt_ff;
      q_pop         = 1'b0;
      mem_we        = 1'b0;
      rd_addr       = '0;
      res_load      = 1'b0;
      res_y_in      = res_y_ff;
      res_seg_in    = res_seg_ff;
      res_status_in = res_status_ff;

      case (state_ff)
         B_IDLE: begin
            if (q_valid && !res_valid_ff) begin
               q_pop   = 1'b1;
               item_in = q_item;
               if (!q_item.is_eval) begin
                  mem_we        = q_item.write_ok;
                  res_load      = 1'b1;
                  res_y_in      = '0;
                  res_seg_in    = '0;
                  res_status_in = 1'b0;
               end else begin
                  state_in = B_CMP0;
               end
            end
         end
         // first point: below range handling or start of the walk
         B_CMP0: begin
            x0_in    = rd_x_ff;
            y0_in    = rd_y_ff;
            seg_in   = '0;
            rd_addr  = AW'(1);
            force_in = 1'b0;
            state_in = B_SEARCH;
            if (item_ff.x < rd_x_ff) begin
               if (item_ff.mode == MODE_ERROR) begin
                  res_load      = 1'b1;
                  res_y_in      = '0;
                  res_seg_in    = '0;
                  res_status_in = 1'b1;
                  state_in      = B_IDLE;
               end else if (item_ff.mode == MODE_EXTRAP) begin
                  force_in = 1'b1;
               end else begin
                  res_load      = 1'b1;
                  res_y_in      = fallback_value;
                  res_seg_in    = 5'h1F;
                  res_status_in = 1'b0;
                  state_in      = B_IDLE;
               end
            end else if (item_ff.x == rd_x_ff) begin
               if (item_ff.mode != MODE_ERROR && item_ff.hint[4]) begin
                  res_load      = 1'b1;
                  res_y_in      = fallback_value;
                  res_seg_in    = 5'h1F;
                  res_status_in = 1'b0;
                  state_in      = B_IDLE;
               end else begin
                  force_in = 1'b1;
               end
            end
         end
         // one segment per cycle; next upper point is read ahead
         B_SEARCH: begin
            rd_addr = is_last ? n_last : AW'(seg_p2);
            if (hit) begin
               x1_in    = rd_x_ff;
               y1_in    = rd_y_ff;
               state_in = B_DIFF;
            end else if (is_last) begin
               res_load      = 1'b1;
               res_y_in      = rd_y_ff;
               res_seg_in    = 5'(n_last);
               res_status_in = 1'b0;
               state_in      = B_IDLE;
            end else begin
               x0_in  = rd_x_ff;
               y0_in  = rd_y_ff;
               seg_in = AW'(seg_p1);
            end
         end
         // exact differences and their magnitudes
         B_DIFF: begin
            ma_in  = dx[32] ? MAG_W'(-dx) : MAG_W'(dx);
            mb_in  = dy[32] ? MAG_W'(-dy) : MAG_W'(dy);
            mc_in  = den[32] ? MAG_W'(-den) : MAG_W'(den);
            neg_in = dx[32] ^ dy[32] ^ den[32];
            if (dx == '0 || dy == '0 || den == '0) begin
               quo_in   = '0;
               sat_in   = 1'b0;
               neg_in   = 1'b0;
               state_in = B_FIN;
            end else begin
               state_in = B_MLO;
            end
         end
         B_MLO: begin
            plo_in   = ma_ff * mb_ff[15:0];
            state_in = B_MHI;
         end
         B_MHI: begin
            phi_in   = ma_ff * mb_ff[32:16];
            state_in = B_MSUM;
         end
         B_MSUM: begin
            prod_in  = 66'(plo_ff) + (66'(phi_ff) << 16);
            state_in = B_DIVI;
         end
         // quotient of 2^33 or more always saturates
         B_DIVI: begin
            sat_in  = (prod_ff[65:33] >= mc_ff);
            rem_in  = prod_ff[65:33];
            plow_in = prod_ff[32:0];
            quo_in  = '0;
            cnt_in  = 6'(DIV_STEPS);
            state_in = (prod_ff[65:33] >= mc_ff) ? B_FIN : B_DIV;
         end
         // restoring divide, one quotient bit per cycle
         B_DIV: begin
            rem_in  = ge ? MAG_W'(r2 - {1'b0, mc_ff}) : r2[MAG_W-1:0];
            plow_in = {plow_ff[MAG_W-2:0], 1'b0};
            quo_in  = {quo_ff[MAG_W-2:0], ge};
            cnt_in  = cnt_ff - 6'd1;
            if (cnt_ff == 6'd1) begin
               state_in = B_FIN;
            end
         end
         // add to y0 and saturate
         B_FIN: begin
            res_load      = 1'b1;
            res_seg_in    = 5'(seg_ff);
            res_status_in = 1'b0;
            if (sat_ff) begin
               res_y_in = neg_ff ? Q_MIN : Q_MAX;
            end else if (sum > 35'sh0_7FFF_FFFF) begin
               res_y_in = Q_MAX;
            end else if (sum < -35'sh0_8000_0000) begin
               res_y_in = Q_MIN;
            end else begin
               res_y_in = 32'(sum);
            end
            state_in = B_IDLE;
         end
         default: begin
            state_in = B_IDLE;
         end
      endcase
   end

   // response slot
   always_comb begin
      if (res_load) begin
         res_valid_in = 1'b1;
      end else if (rsp_pop) begin
         res_valid_in = 1'b0;
      end else begin
         res_valid_in = res_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= B_IDLE;
         res_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         res_valid_ff <= res_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      item_ff       <= item_in;
      seg_ff        <= seg_in;
      force_ff      <= force_in;
      x0_ff         <= x0_in;
      y0_ff         <= y0_in;
      x1_ff         <= x1_in;
      y1_ff         <= y1_in;
      ma_ff         <= ma_in;
      mb_ff         <= mb_in;
      mc_ff         <= mc_in;
      neg_ff        <= neg_in;
      sat_ff        <= sat_in;
      plo_ff        <= plo_in;
      phi_ff        <= phi_in;
      prod_ff       <= prod_in;
      rem_ff        <= rem_in;
      plow_ff       <= plow_in;
      quo_ff        <= quo_in;
      cnt_ff        <= cnt_in;
      res_y_ff      <= res_y_in;
      res_seg_ff    <= res_seg_in;
      res_status_ff <= res_status_in;
   end

   // table write and registered read
   always_ff @(posedge clock) begin
      if (mem_we) begin
         mem_x_ff[AW'(q_item.idx)] <= q_item.x;
         mem_y_ff[AW'(q_item.idx)] <= q_item.y;
      end
      rd_x_ff <= mem_x_ff[rd_addr];
      rd_y_ff <= mem_y_ff[rd_addr];
   end

   assign rsp_empty         = !res_valid_ff;
   assign rsp_y_result      = res_y_ff;
   assign rsp_segment_index = res_seg_ff;
   assign rsp_status        = res_status_ff;

`ifndef SYNTH
   // a response is never loaded over one still waiting
   a_no_overwrite: assert property (@(posedge clock) disable iff (reset)
      !(res_load && res_valid_ff))
      else $error("response slot overwritten");

   // the walk never passes the last valid point
   a_search_bound: assert property (@(posedge clock) disable iff (reset)
      (state_ff == B_SEARCH) |-> (seg_ff < n_last))
      else $error("segment search past table end");

   // requests leave the queue only between items
   a_pop_idle: assert property (@(posedge clock) disable iff (reset)
      q_pop |-> (state_ff == B_IDLE) && q_valid)
      else $error("queue popped while busy");

   // divider count never runs out while dividing; a saturating quotient skips the divide
   a_div_count: assert property (@(posedge clock) disable iff (reset)
      (state_ff == B_DIV) |-> (cnt_ff != 6'd0))
      else $error("divider count underflow");
`endif

endmodule

@@ dv/pli_checker.sv @@
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// pli_checker - response predictor and scoreboard for the interpolator
// Watches the request, response and CSR channels. Keeps its own copy of the
// breakpoint table and registers, computes the expected response of every
// accepted request and compares each popped response against the oldest one.
// ----------------------------------------------------------------------------
module pli_checker import pli_pkg::*; (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_push,
   input  logic               req_full,
   input  logic               req_action,
   input  logic [3:0]         req_entry_index,
   input  logic signed [31:0] req_x_value,
   input  logic signed [31:0] req_y_value,
   input  logic signed [4:0]  req_segment_hint,
   input  logic               rsp_empty,
   input  logic               rsp_pop,
   input  logic signed [31:0] rsp_y_result,
   input  logic signed [4:0]  rsp_segment_index,
   input  logic               rsp_status,
   input  logic               csr_valid,
   input  logic               csr_ready,
   input  logic [1:0]         csr_index,
   input  logic [31:0]        csr_wdata,
   output int                 err_count,
   output int                 rsp_count,
   output int                 exp_left
);

   typedef struct packed {
      logic signed [31:0] y;
      logic signed [4:0]  seg;
      logic               status;
   } interp_rsp_type;

   logic signed [31:0] tab_x [16];
   logic signed [31:0] tab_y [16];
   logic [4:0]         npoints;
   logic [1:0]         below_mode;
   logic signed [31:0] fallback;
   interp_rsp_type     expected_q [$];

   // linear interpolation on segment i, exact products, truncating divide
   function automatic logic signed [31:0] interp_seg(int i, logic signed [31:0] xq);
      longint      x0, x1, y0, y1, dx, dy, den, sum;
      logic [32:0] adx, ady, aden;
      logic [65:0] prod, quo;
      bit          neg;
      x0 = tab_x[i];
      x1 = tab_x[i+1];
      y0 = tab_y[i];
      y1 = tab_y[i+1];
      dx = longint'(xq) - x0;
      dy = y1 - y0;
      den = x1 - x0;
      if (den == 0 || dx == 0 || dy == 0) return tab_y[i];
      neg = ((dx < 0) != (dy < 0)) != (den < 0);
      adx = (dx < 0) ? -dx : dx;
      ady = (dy < 0) ? -dy : dy;
      aden = (den < 0) ? -den : den;
      prod = {33'b0, adx} * {33'b0, ady};
      quo = prod / {33'b0, aden};
      if (quo > 66'hFF_FFFF_FFFF) return neg ? Q_MIN : Q_MAX;
      sum = neg ? y0 - longint'({24'b0, quo[39:0]}) : y0 + longint'({24'b0, quo[39:0]});
      if (sum > longint'(Q_MAX)) sum = Q_MAX;
      if (sum < longint'(Q_MIN)) sum = Q_MIN;
      return sum[31:0];
   endfunction

   // expected response of one evaluate request
   function automatic interp_rsp_type eval_query(logic signed [31:0] xq,
                                                 logic signed [4:0] hint);
      interp_rsp_type r;
      int             n;
      bit             found, hit;
      r = '0;
      found = 0;
      n = npoints;
      if (n < 2) n = 2;
      if (n > 16) n = 16;
      if (xq < tab_x[0]) begin
         found = 1;
         if (below_mode == MODE_CODE_ERROR) begin
            r.status = 1'b1;
         end else if (below_mode == MODE_CODE_EXTRAP) begin
            r.y = interp_seg(0, xq);
         end else begin
            r.seg = -5'sd1;
            r.y = fallback;
         end
      end else if (xq == tab_x[0]) begin
         found = 1;
         if (below_mode != MODE_CODE_ERROR && hint < 0) begin
            r.seg = -5'sd1;
            r.y = fallback;
         end else begin
            r.y = interp_seg(0, xq);
         end
      end else begin
         for (int i = 0; i + 1 < n && !found; i++) begin
            hit = (int'(hint) == i) ? (xq <= tab_x[i+1]) : (xq < tab_x[i+1]);
            if (hit) begin
               found = 1;
               r.seg = i[4:0];
               r.y = interp_seg(i, xq);
            end
         end
      end
      if (!found) begin
         r.seg = 5'(n - 1);
         r.y = tab_y[n-1];
      end
      return r;
   endfunction

   assign exp_left = expected_q.size();

   always @(posedge clock) begin
      interp_rsp_type got, want, pred;
      if (reset) begin
         npoints = 5'd2;
         below_mode = MODE_CODE_ERROR;
         fallback = '0;
         expected_q.delete();
         err_count = 0;
         rsp_count = 0;
      end else begin
         // compare popped response with the oldest expectation
         if (rsp_pop && !rsp_empty) begin
            rsp_count++;
            got = '{rsp_y_result, rsp_segment_index, rsp_status};
            if (expected_q.size() == 0) begin
               err_count++;
               if (err_count <= 10)
                  $display("%t unexpected response y=%h seg=%0d st=%b", $realtime,
                           got.y, got.seg, got.status);
            end else begin
               want = expected_q.pop_front();
               if (got !== want) begin
                  err_count++;
                  if (err_count <= 10)
                     $display("%t mismatch: exp y=%h seg=%0d st=%b, got y=%h seg=%0d st=%b",
                              $realtime, want.y, want.seg, want.status,
                              got.y, got.seg, got.status);
               end
            end
         end
         // predict accepted request
         if (req_push && !req_full) begin
            if (req_action == ACT_WRITE) begin
               tab_x[req_entry_index] = req_x_value;
               tab_y[req_entry_index] = req_y_value;
               pred = '0;
            end else begin
               pred = eval_query(req_x_value, req_segment_hint);
            end
            expected_q = {expected_q, pred};
         end
         // register writes
         if (csr_valid && csr_ready) begin
            case (csr_index)
               CSR_POINT_COUNT: npoints = csr_wdata[4:0];
               CSR_BELOW_MODE:  below_mode = csr_wdata[1:0];
               CSR_FALLBACK:    fallback = csr_wdata;
               default: ;
            endcase
         end
      end
   end

endmodule

@@ dv/piecewise_linear_interpolator_core_tb.sv @@
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// piecewise_linear_interpolator_core_tb - testbench top
// Loads breakpoint tables, sweeps point count, below-range mode and fallback
// value, and sends directed then random queries around the breakpoints with
// random idling and backpressure. Checking is done by pli_checker.
// ----------------------------------------------------------------------------
module piecewise_linear_interpolator_core_tb;
   import pli_pkg::*;

   logic               clock = 1'b0;
   logic               reset = 1'b1;
   logic               req_push = 1'b0;
   logic               req_full;
   logic               req_action = ACT_WRITE;
   logic [3:0]         req_entry_index = '0;
   logic signed [31:0] req_x_value = '0;
   logic signed [31:0] req_y_value = '0;
   logic signed [4:0]  req_segment_hint = '0;
   logic               rsp_empty;
   logic               rsp_pop = 1'b0;
   logic signed [31:0] rsp_y_result;
   logic signed [4:0]  rsp_segment_index;
   logic               rsp_status;
   logic               csr_valid = 1'b0;
   logic               csr_ready;
   logic [1:0]         csr_index = '0;
   logic [31:0]        csr_wdata = '0;

   int                 err_count, rsp_count, exp_left;
   int                 sent_count = 0;
   bit                 quiet = 0;      // no idling on either side
   bit                 stall_req = 0;  // ask the receiver for a long hold-off
   logic signed [31:0] bx [16];

   always #5 clock = ~clock;

   piecewise_linear_interpolator_core i_dut (.*);

   pli_checker i_checker (.*);

   // response side: random pop, with one long hold-off on request
   initial begin
      forever begin
         @(posedge clock);
         if (stall_req) begin
            stall_req = 0;
            rsp_pop <= 1'b0;
            repeat (300) @(posedge clock);
         end
         rsp_pop <= quiet ? 1'b1 : ($urandom_range(99) >= 9);
      end
   end

   // one request; returns on the edge that accepts it, or after a random idle that follows
   task automatic send_req(logic act, logic [3:0] idx, logic signed [31:0] xv,
                           logic signed [31:0] yv, logic signed [4:0] hint);
      req_push <= 1'b1;
      req_action <= act;
      req_entry_index <= idx;
      req_x_value <= xv;
      req_y_value <= yv;
      req_segment_hint <= hint;
      do @(posedge clock); while (req_full);
      sent_count++;
      if (!quiet && $urandom_range(99) < 9) begin
         req_push <= 1'b0;
         @(posedge clock);
      end
   endtask

   // wait until every request has been answered
   task automatic drain();
      req_push <= 1'b0;
      @(posedge clock);
      while (rsp_count != sent_count) @(posedge clock);
      repeat (60) @(posedge clock);
   endtask

   task automatic set_reg(logic [1:0] idx, logic [31:0] val);
      drain();
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_wdata <= val;
      do @(posedge clock); while (!csr_ready);
      csr_valid <= 1'b0;
      @(posedge clock);
   endtask

   // write all 16 entries with ascending x; narrow tables give duplicates
   task automatic load_table();
      int          spread;
      logic [31:0] base;
      int          xs [16];
      spread = $urandom_range(3);
      base = $urandom;
      for (int i = 0; i < 16; i++) begin
         case (spread)
            0: xs[i] = $urandom;
            1: xs[i] = $signed(base) / 2 + int'($urandom_range(0, 40));
            default: xs[i] = $signed(base) / 4 + int'($urandom_range(0, 32'h40_0000));
         endcase
      end
      xs.sort();
      for (int i = 0; i < 16; i++) begin
         bx[i] = xs[i];
         send_req(ACT_WRITE, i[3:0], xs[i], $urandom, 5'($urandom));
      end
   endtask

   task automatic random_query();
      int                 k;
      logic signed [31:0] xq;
      logic signed [4:0]  hint;
      k = $urandom_range(15);
      case ($urandom_range(3))
         0: xq = $urandom;
         1: xq = bx[k];
         default: xq = bx[k] + int'($urandom_range(0, 4)) - 2;
      endcase
      case ($urandom_range(3))
         0: hint = -5'sd1;
         1: hint = 5'($urandom);
         default: hint = 5'($urandom_range(0, 15) % 16 == 0 ? 0 : k - 1);
      endcase
      send_req(ACT_EVAL, 4'($urandom), xq, $urandom, hint);
   endtask

   // run limit
   initial begin
      #5ms;
      $display("RESULT: ERROR");
      $finish;
   end

   initial begin
      logic [1:0] modes [4];
      repeat (4) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // directed: unit-spaced table, last x at Q_MAX, with extreme y values
      for (int i = 0; i < 16; i++) begin
         bx[i] = (i == 15) ? Q_MAX : i * 32'sh1_0000 - 32'sh8_0000;
         send_req(ACT_WRITE, i[3:0], bx[i], (i % 2) ? Q_MAX : Q_MIN, '0);
      end
      set_reg(CSR_POINT_COUNT, 32'd16);
      send_req(ACT_EVAL, 4'hf, -32'sh9_0000, '0, -5'sd1);      // below, error
      send_req(ACT_EVAL, 4'h0, bx[0], '0, -5'sd1);             // at first x
      send_req(ACT_EVAL, 4'h0, bx[3], '0, 5'sd2);              // hinted upper end
      send_req(ACT_EVAL, 4'h0, bx[3], '0, -5'sd1);
      send_req(ACT_EVAL, 4'h0, bx[2] + 32'sh8000, '0, 5'sd15); // midpoint of a full-swing segment
      send_req(ACT_EVAL, 4'h0, Q_MAX, '0, 5'sb10000);          // at last point
      set_reg(CSR_BELOW_MODE, 32'hffff_fff1);
      send_req(ACT_EVAL, 4'h0, Q_MIN, '0, -5'sd1);             // extrapolate
      send_req(ACT_EVAL, 4'h0, bx[0], '0, -5'sd1);
      set_reg(CSR_FALLBACK, Q_MIN);
      set_reg(CSR_BELOW_MODE, {30'd0, MODE_CODE_FALLBACK});
      send_req(ACT_EVAL, 4'h0, Q_MIN, '0, 5'sd0);              // fallback
      send_req(ACT_EVAL, 4'h0, bx[0], '0, 5'sd0);
      set_reg(CSR_BELOW_MODE, {30'd0, MODE_CODE_SPARE});       // mode three
      send_req(ACT_EVAL, 4'h0, bx[0], '0, -5'sd1);
      set_reg(CSR_POINT_COUNT, 32'd0);                         // clamps to 2
      send_req(ACT_EVAL, 4'h0, Q_MAX, '0, -5'sd1);
      set_reg(CSR_POINT_COUNT, 32'hffff_ffff);                 // clamps to 16
      send_req(ACT_EVAL, 4'h0, bx[9] + 1, '0, 5'sd9);

      // random phases over several settings
      modes = '{MODE_CODE_ERROR, MODE_CODE_EXTRAP, MODE_CODE_FALLBACK, MODE_CODE_SPARE};
      for (int ph = 0; ph < 4; ph++) begin
         set_reg(CSR_POINT_COUNT, (ph == 0) ? 32'd2 : (ph == 1) ? 32'd16 : $urandom);
         set_reg(CSR_BELOW_MODE, 32'({$urandom, modes[ph]}));
         set_reg(CSR_FALLBACK, (ph == 1) ? Q_MAX : $urandom);
         quiet = (ph == 2);
         load_table();
         if (ph == 1) stall_req = 1;
         for (int j = 0; j < 95; j++) begin
            if ($urandom_range(99) < 12) begin
               // table disturbance
               k_write: begin
                  logic [3:0] wi;
                  wi = 4'($urandom);
                  bx[wi] = $urandom;
                  send_req(ACT_WRITE, wi, bx[wi], $urandom, 5'($urandom));
               end
            end else begin
               random_query();
            end
            if (ph == 0 && j == 50) drain();
         end
      end
      quiet = 0;

      drain();
      if (err_count == 0 && exp_left == 0) begin
         $display("RESULT: OK");
      end else begin
         $display("RESULT: ERROR");
      end
      $finish;
   end

endmodule
